// ===== hdl/g2g_pkg.sv =====
package g2g_pkg;

  // Data widths
  localparam int unsigned POSE_W    = 32;
  localparam int unsigned DIFF_W    = POSE_W + 1;   // goal minus pose
  localparam int unsigned HEAD_W    = 15;
  localparam int unsigned VEC_W     = 51;           // CORDIC x/y, |d| << 16 plus growth
  localparam int unsigned ANG_W     = 19;           // CORDIC angle, rad * 65536
  localparam int unsigned PATH_W    = 16;           // path angle, rad * 4096
  localparam int unsigned ERR_W     = 18;           // heading error, rad * 4096
  localparam int unsigned CORDIC_N  = 16;

  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Angle constants, rad * 4096
  localparam logic signed [PATH_W-1:0] ANG_HALF_PI = 16'sd6434;
  localparam logic signed [ERR_W-1:0]  ANG_PI      = 18'sd12868;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X      = 3'd0,
    REG_GOAL_Y      = 3'd1,
    REG_ARRIVE_TOL  = 3'd2,
    REG_DEADBAND    = 3'd3,
    REG_FWD_CONE    = 3'd4,
    REG_FWD_SPEED   = 3'd5,
    REG_TURN_SPEED  = 3'd6
  } g2g_reg_t;

  // Reset values
  localparam logic [15:0] RST_ARRIVE_TOL = 16'd1311;
  localparam logic [13:0] RST_DEADBAND   = 14'd214;
  localparam logic [13:0] RST_FWD_CONE   = 14'd3195;
  localparam logic [15:0] RST_FWD_SPEED  = 16'd6554;
  localparam logic [14:0] RST_TURN_SPEED = 15'd2048;

  typedef struct packed {
    logic signed [POSE_W-1:0] goal_x;
    logic signed [POSE_W-1:0] goal_y;
    logic [15:0]              arrive_tolerance;
    logic [13:0]              heading_deadband;
    logic [13:0]              forward_cone;
    logic [15:0]              forward_speed;
    logic [14:0]              turn_speed;
  } g2g_cfg_t;

  // Per-item flags that ride alongside the CORDIC vector
  typedef struct packed {
    logic                     dx_zero;
    logic                     dy_zero;
    logic                     dx_neg;
    logic                     dy_neg;
    logic                     near;
    logic signed [HEAD_W-1:0] yaw;
  } g2g_side_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    g2g_side_t               side;
  } g2g_vec_t;

  // atan(2^-i) in rad * 65536, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      0:       a = 19'sd51472;
      1:       a = 19'sd30386;
      2:       a = 19'sd16055;
      3:       a = 19'sd8150;
      4:       a = 19'sd4091;
      5:       a = 19'sd2047;
      6:       a = 19'sd1024;
      7:       a = 19'sd512;
      8:       a = 19'sd256;
      9:       a = 19'sd128;
      10:      a = 19'sd64;
      11:      a = 19'sd32;
      12:      a = 19'sd16;
      13:      a = 19'sd8;
      14:      a = 19'sd4;
      15:      a = 19'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/g2g_front.sv =====
module g2g_front import g2g_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  g2g_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [POSE_W-1:0] pose_x,
  input  logic signed [POSE_W-1:0] pose_y,
  input  logic signed [HEAD_W-1:0] pose_heading,
  output logic                     out_valid,
  input  logic                     out_ready,
  output g2g_vec_t                 out_vec
);

  // Stage 1: offsets to the goal
  logic                     v1;
  logic                     rdy1;
  logic signed [DIFF_W-1:0] dx1;
  logic signed [DIFF_W-1:0] dy1;
  logic signed [HEAD_W-1:0] yaw1;

  // Stage 2: magnitudes, flags, squares
  logic                     v2;
  logic                     rdy2;
  logic [DIFF_W-1:0]        adx2;
  logic [DIFF_W-1:0]        ady2;
  logic [31:0]              sqx2;
  logic [31:0]              sqy2;
  logic                     big2;
  g2g_side_t                side2;

  // Stage 3: distance compare, CORDIC start vector
  logic                     v3;
  logic                     rdy3;
  g2g_vec_t                 vec3;

  logic [31:0]              tol_sq;
  logic [DIFF_W-1:0]        adx_c;
  logic [DIFF_W-1:0]        ady_c;
  logic [DIFF_W:0]          dist_sq;
  logic                     near_c;
  g2g_side_t                side3_c;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign out_valid = v3;
  assign out_vec   = vec3;

  // Tolerance squared; config must only change while idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    tol_sq <= cfg.arrive_tolerance * cfg.arrive_tolerance;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      dx1  <= DIFF_W'(cfg.goal_x) - DIFF_W'(pose_x);
      dy1  <= DIFF_W'(cfg.goal_y) - DIFF_W'(pose_y);
      yaw1 <= pose_heading;
    end
  end

  assign adx_c = dx1[DIFF_W-1] ? DIFF_W'(-dx1) : DIFF_W'(dx1);
  assign ady_c = dy1[DIFF_W-1] ? DIFF_W'(-dy1) : DIFF_W'(dy1);

  // Stage 2 payload
  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      adx2         <= adx_c;
      ady2         <= ady_c;
      sqx2         <= adx_c[15:0] * adx_c[15:0];
      sqy2         <= ady_c[15:0] * ady_c[15:0];
      big2         <= (adx_c[DIFF_W-1:16] != '0) || (ady_c[DIFF_W-1:16] != '0);
      side2.dx_zero <= (dx1 == '0);
      side2.dy_zero <= (dy1 == '0);
      side2.dx_neg  <= dx1[DIFF_W-1];
      side2.dy_neg  <= dy1[DIFF_W-1];
      side2.near    <= 1'b0;
      side2.yaw     <= yaw1;
    end
  end

  assign dist_sq = {1'b0, sqx2} + {1'b0, sqy2};
  assign near_c  = !big2 && (dist_sq < {1'b0, tol_sq});

  // Distance flag joins the side fields
  always_comb begin
    side3_c      = side2;
    side3_c.near = near_c;
  end

  // Stage 3 payload
  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      vec3.x    <= $signed({2'b00, adx2, 16'h0000});
      vec3.y    <= $signed({2'b00, ady2, 16'h0000});
      vec3.z    <= '0;
      vec3.side <= side3_c;
    end
  end

endmodule

// ===== hdl/g2g_cell.sv =====
module g2g_cell import g2g_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  g2g_vec_t in_vec,
  output logic     out_valid,
  input  logic     out_ready,
  output g2g_vec_t out_vec
);

  localparam logic signed [ANG_W-1:0] ANGLE = atan_step(STAGE);

  logic                    vld;
  g2g_vec_t                vec;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_vec   = vec;

  assign xs = in_vec.x >>> STAGE;
  assign ys = in_vec.y >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // One vectoring micro-rotation: drive y toward zero
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      vec.side <= in_vec.side;
      if (!in_vec.y[VEC_W-1]) begin
        vec.x <= in_vec.x + ys;
        vec.y <= in_vec.y - xs;
        vec.z <= in_vec.z + ANGLE;
      end else begin
        vec.x <= in_vec.x - ys;
        vec.y <= in_vec.y + xs;
        vec.z <= in_vec.z - ANGLE;
      end
    end
  end

endmodule

// ===== hdl/g2g_back.sv =====
module g2g_back import g2g_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  g2g_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  g2g_vec_t    in_vec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] forward_cmd,
  output logic [15:0] turn_cmd,
  output logic        arrived
);

  // Stage 1: path angle
  logic                     v1;
  logic                     rdy1;
  logic signed [PATH_W-1:0] path1;
  logic                     dx_neg1;
  logic                     near1;
  logic signed [HEAD_W-1:0] yaw1;

  // Stage 2: output register
  logic                     v2;
  logic                     rdy2;

  logic [ANG_W-1:0]         z_clamp;
  logic [ANG_W-1:0]         z_rnd;
  logic signed [PATH_W-1:0] mag;
  logic signed [PATH_W-1:0] path_c;

  logic signed [ERR_W-1:0]  err0;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         aerr;
  logic [15:0]              fwd_c;
  logic [15:0]              turn_c;

  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  // Clamp at zero, round rad*65536 down to rad*4096
  assign z_clamp = in_vec.z[ANG_W-1] ? '0 : ANG_W'(in_vec.z);
  assign z_rnd   = z_clamp + ANG_W'(8);
  assign mag     = $signed(PATH_W'(z_rnd[ANG_W-1:4]));

  // Axis cases bypass the CORDIC result
  always_comb begin
    if (in_vec.side.dx_zero) begin
      if (in_vec.side.dy_zero)     path_c = '0;
      else if (in_vec.side.dy_neg) path_c = -ANG_HALF_PI;
      else                         path_c = ANG_HALF_PI;
    end else if (in_vec.side.dy_zero) begin
      path_c = '0;
    end else if (in_vec.side.dx_neg != in_vec.side.dy_neg) begin
      path_c = -mag;
    end else begin
      path_c = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      path1   <= path_c;
      dx_neg1 <= in_vec.side.dx_neg;
      near1   <= in_vec.side.near;
      yaw1    <= in_vec.side.yaw;
    end
  end

  // Heading error, folded by pi when the goal is behind in x
  assign err0 = ERR_W'(path1) - ERR_W'(yaw1);

  always_comb begin
    if (!dx_neg1)           err = err0;
    else if (err0 < 0)      err = err0 + ANG_PI;
    else                    err = err0 - ANG_PI;
  end

  assign aerr = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  always_comb begin
    if (aerr < {4'b0000, cfg.heading_deadband}) turn_c = '0;
    else if (err > 0)                           turn_c = {1'b0, cfg.turn_speed};
    else                                        turn_c = 16'(-{1'b0, cfg.turn_speed});
  end

  // Cone test is one-sided
  assign fwd_c = (near1 || (err >= $signed({4'b0000, cfg.forward_cone}))) ? '0
               : cfg.forward_speed;

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      forward_cmd <= fwd_c;
      turn_cmd    <= turn_c;
      arrived     <= (fwd_c == '0) && (turn_c == '0);
    end
  end

endmodule

// ===== hdl/go_to_goal_steering_command_core.sv =====
// Go-to-goal steering: one pose in, one drive command out.
// Slave stream carries the odometry pose; master stream carries the command
// (forward speed, signed turn rate, arrived flag). The config channel writes
// the goal point, arrival tolerance, heading deadband, forward cone and the
// two speed magnitudes; write it only while no pose is in flight.
// From pose transfer to command valid a pose passes three front stages
// (goal offset, magnitudes and squares, distance compare), a chain of 16
// CORDIC vectoring cells, one rounding stage and the output register.
// Throughput is one pose per cycle while the receiver keeps up; each cell
// handles one rotation, so the chain length sets the latency and not the rate.
// Reset empties the pipeline and loads the default config with the goal at
// the origin. When the receiver stalls, the output register holds its
// command while earlier stages keep filling empty slots; s_axis_tready drops
// only when every stage is occupied.
module go_to_goal_steering_command_core import g2g_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // pose_x [31:0], pose_y [63:32], pose_heading [78:64], zero pad [79]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // forward_cmd [15:0], turn_cmd [31:16], arrived [32], zero pad [39:33]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  g2g_cfg_t    cfg;
  g2g_vec_t    vec   [CORDIC_N+1];
  logic        vld   [CORDIC_N+1];
  logic        rdy   [CORDIC_N+1];
  logic [15:0] forward_cmd;
  logic [15:0] turn_cmd;
  logic        arrived;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_x           <= '0;
      cfg.goal_y           <= '0;
      cfg.arrive_tolerance <= RST_ARRIVE_TOL;
      cfg.heading_deadband <= RST_DEADBAND;
      cfg.forward_cone     <= RST_FWD_CONE;
      cfg.forward_speed    <= RST_FWD_SPEED;
      cfg.turn_speed       <= RST_TURN_SPEED;
    end else if (cfg_valid && cfg_ready) begin
      case (g2g_reg_t'(cfg_index))
        REG_GOAL_X:     cfg.goal_x           <= $signed(cfg_data);
        REG_GOAL_Y:     cfg.goal_y           <= $signed(cfg_data);
        REG_ARRIVE_TOL: cfg.arrive_tolerance <= cfg_data[15:0];
        REG_DEADBAND:   cfg.heading_deadband <= cfg_data[13:0];
        REG_FWD_CONE:   cfg.forward_cone     <= cfg_data[13:0];
        REG_FWD_SPEED:  cfg.forward_speed    <= cfg_data[15:0];
        REG_TURN_SPEED: cfg.turn_speed       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Offsets, magnitudes and distance test
  g2g_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .pose_x       ($signed(s_axis_tdata[31:0])),
    .pose_y       ($signed(s_axis_tdata[63:32])),
    .pose_heading ($signed(s_axis_tdata[78:64])),
    .out_valid    (vld[0]),
    .out_ready    (rdy[0]),
    .out_vec      (vec[0])
  );

  // CORDIC cell chain
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cell
    g2g_cell #(
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_vec    (vec[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_vec   (vec[i+1])
    );
  end

  // Path angle, error and command decisions
  g2g_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (vld[CORDIC_N]),
    .in_ready    (rdy[CORDIC_N]),
    .in_vec      (vec[CORDIC_N]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .forward_cmd (forward_cmd),
    .turn_cmd    (turn_cmd),
    .arrived     (arrived)
  );

  assign m_axis_tdata = {7'b0000000, arrived, turn_cmd, forward_cmd};

endmodule
